// ===== rtl/abas_pkg.sv =====
// ----------------------------------------------------------------------------
// abas_pkg: shared types and constants of the adaptive block ARQ sender
// Response codes, result actions, the command word that runs between the
// front and the back, and reset values of the configuration registers.
// ----------------------------------------------------------------------------
package abas_pkg;

	localparam int SIZE_W      = 16;
	localparam int TRIES_W     = 4;
	localparam int ACTION_W    = 2;
	localparam int MODE_W      = 2;
	localparam int BYTE_W      = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam int DEF_MAX_ATTEMPTS = 10;
	localparam int DEF_CANCEL_BURST = 6;

	localparam logic [SIZE_W-1:0] INIT_SIZE_RST = 16'd512;
	localparam logic [SIZE_W-1:0] MAX_SIZE_RST  = 16'd8192;
	localparam logic [SIZE_W-1:0] GROW_STEP     = 16'd512;
	localparam logic [SIZE_W-1:0] MIN_SIZE      = 16'h0040;

	localparam logic [BYTE_W-1:0] CODE_ACK     = 8'h06;
	localparam logic [BYTE_W-1:0] CODE_NAK     = 8'h15;
	localparam logic [BYTE_W-1:0] CODE_CAN     = 8'h18;
	localparam logic [BYTE_W-1:0] CODE_TIMEOUT = 8'h00;

	// configuration register indexes
	localparam logic REG_INIT_SIZE = 1'b0;
	localparam logic REG_MAX_SIZE  = 1'b1;

	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RESP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ABORT = 2'd2;

	localparam logic [ACTION_W-1:0] ACT_TX     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ACKED  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_RETX   = 2'd3;

	// one classified item: a single result, or a burst of cancel results
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [SIZE_W-1:0]   size;
		logic                burst;
	} cmd_t;

	// queue status toward the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== rtl/abas_front.sv =====
// ----------------------------------------------------------------------------
// abas_front: item classifier
// Takes input words, keeps the retry count and the preferred block size,
// and turns each item into at most one command for the queue.
// ----------------------------------------------------------------------------
module abas_front #(
	parameter int MAX_ATTEMPTS = abas_pkg::DEF_MAX_ATTEMPTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic                          reg_index,
	input  logic [abas_pkg::SIZE_W-1:0]   wr_data,
	input  logic                          accept,
	input  logic [abas_pkg::MODE_W-1:0]   mode,
	input  logic [abas_pkg::BYTE_W-1:0]   resp_byte,
	output logic                          push,
	output abas_pkg::cmd_t                push_cmd
);

	localparam logic [abas_pkg::TRIES_W-1:0] TRIES_FULL =
		abas_pkg::TRIES_W'(MAX_ATTEMPTS - 1);

	logic                          waiting_q, waiting_d;
	logic [abas_pkg::TRIES_W-1:0]  tries_q, tries_d;
	logic [abas_pkg::SIZE_W-1:0]   pref_q, pref_d;
	logic [abas_pkg::SIZE_W-1:0]   max_q;
	logic [abas_pkg::SIZE_W:0]     grown;
	logic [abas_pkg::SIZE_W-1:0]   halved;
	logic [abas_pkg::SIZE_W-1:0]   acked_size;

	// size after a clean or a retried acknowledgment
	always_comb begin
		grown  = {1'b0, pref_q} + {1'b0, abas_pkg::GROW_STEP};
		halved = pref_q >> 1;
		if (tries_q == TRIES_FULL) begin
			if (grown > {1'b0, max_q})
				acked_size = max_q;
			else
				acked_size = grown[abas_pkg::SIZE_W-1:0];
		end else begin
			if (halved < abas_pkg::MIN_SIZE)
				acked_size = abas_pkg::MIN_SIZE;
			else
				acked_size = halved;
		end
	end

	always_comb begin
		logic cancel;
		cancel    = 1'b0;
		waiting_d = waiting_q;
		tries_d   = tries_q;
		pref_d    = pref_q;
		push      = 1'b0;
		push_cmd  = '{action: abas_pkg::ACT_TX, size: pref_q, burst: 1'b0};
		if (accept) begin
			unique case (mode)
				abas_pkg::MODE_START: begin
					waiting_d = 1'b1;
					tries_d   = TRIES_FULL;
					push      = 1'b1;
				end
				abas_pkg::MODE_ABORT: begin
					cancel = waiting_q;
				end
				abas_pkg::MODE_RESP: begin
					if (waiting_q) begin
						priority if (resp_byte == abas_pkg::CODE_CAN) begin
							cancel = 1'b1;
						end else if (resp_byte == abas_pkg::CODE_ACK) begin
							pref_d          = acked_size;
							waiting_d       = 1'b0;
							tries_d         = '0;
							push            = 1'b1;
							push_cmd.action = abas_pkg::ACT_ACKED;
							push_cmd.size   = acked_size;
						end else if (resp_byte == abas_pkg::CODE_NAK ||
						             resp_byte == abas_pkg::CODE_TIMEOUT) begin
							if (tries_q == '0) begin
								cancel = 1'b1;
							end else begin
								tries_d         = tries_q - 1'b1;
								push            = 1'b1;
								push_cmd.action = abas_pkg::ACT_RETX;
							end
						end else begin
							cancel = 1'b0;
						end
					end
				end
				default: begin
					cancel = 1'b0;
				end
			endcase
			if (cancel) begin
				waiting_d       = 1'b0;
				tries_d         = '0;
				push            = 1'b1;
				push_cmd.action = abas_pkg::ACT_CANCEL;
				push_cmd.burst  = 1'b1;
			end
		end
		// writes are to come only while idle; the block itself does not enforce it
		if (wr_en && reg_index == abas_pkg::REG_INIT_SIZE)
			pref_d = wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			tries_q   <= '0;
			pref_q    <= abas_pkg::INIT_SIZE_RST;
			max_q     <= abas_pkg::MAX_SIZE_RST;
		end else begin
			waiting_q <= waiting_d;
			tries_q   <= tries_d;
			pref_q    <= pref_d;
			if (wr_en && reg_index == abas_pkg::REG_MAX_SIZE)
				max_q <= wr_data;
		end
	end

endmodule

// ===== rtl/abas_queue.sv =====
// ----------------------------------------------------------------------------
// abas_queue: command queue
// Short register queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module abas_queue #(
	parameter int DEPTH = abas_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  abas_pkg::cmd_t         push_cmd,
	input  logic                   pop,
	output abas_pkg::cmd_t         head,
	output abas_pkg::queue_stat_t  stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	abas_pkg::cmd_t      mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push, do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/abas_back.sv =====
// ----------------------------------------------------------------------------
// abas_back: result sequencer
// Expands queued commands into result words and holds them in the output
// register until taken.
// ----------------------------------------------------------------------------
module abas_back #(
	parameter int CANCEL_BURST = abas_pkg::DEF_CANCEL_BURST
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  abas_pkg::cmd_t                 head,
	input  abas_pkg::queue_stat_t          stat,
	output logic                           pop,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [abas_pkg::ACTION_W-1:0]  action,
	output logic [abas_pkg::SIZE_W-1:0]    block_size,
	output logic                           aborted,
	output logic                           last
);

	localparam int BURST_W = (CANCEL_BURST > 1) ? $clog2(CANCEL_BURST) : 1;
	localparam logic [BURST_W-1:0] BURST_END = BURST_W'(CANCEL_BURST - 1);

	logic [BURST_W-1:0] cnt_q;
	logic               load, final_word;

	assign load       = !stat.empty && (!res_valid || res_ready);
	assign final_word = !head.burst || (cnt_q == BURST_END);
	assign pop        = load && final_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (load) begin
				res_valid <= 1'b1;
				cnt_q     <= final_word ? '0 : cnt_q + 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			action     <= head.action;
			block_size <= head.size;
			aborted    <= head.burst && final_word;
			last       <= final_word;
		end
	end

endmodule

// ===== rtl/adaptive_block_arq_sender_unit.sv =====
// ----------------------------------------------------------------------------
// adaptive_block_arq_sender_unit: adaptive block ARQ sender control
// Classifies start, response and abort words, keeps the retry count and the
// adaptive block size, and issues transmit, retransmit, acknowledge and
// cancel-burst result words.
// ----------------------------------------------------------------------------
// Path: an accepted input word enters the command queue, then the output register.
// Throughput: one input word per cycle while each item yields one result and
//   res_ready is high; a cancel burst holds the output for CANCEL_BURST words,
//   and the two-entry command queue lets the front accept words until it fills.
// Reset: arst_n clears the retry state, the queue and the output valid at
//   once; the block size returns to 512 and the cap to 8192.
module adaptive_block_arq_sender_unit #(
	parameter int MAX_ATTEMPTS = abas_pkg::DEF_MAX_ATTEMPTS,
	parameter int CANCEL_BURST = abas_pkg::DEF_CANCEL_BURST
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           wr_en,
	input  logic                           reg_index,
	input  logic [abas_pkg::SIZE_W-1:0]    wr_data,
	// input words
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [abas_pkg::MODE_W-1:0]    mode,
	input  logic [abas_pkg::BYTE_W-1:0]    resp_byte,
	// result words
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [abas_pkg::ACTION_W-1:0]  action,
	output logic [abas_pkg::SIZE_W-1:0]    block_size,
	output logic                           aborted,
	output logic                           last
);

	logic                  accept;
	logic                  push;
	logic                  pop;
	abas_pkg::cmd_t        push_cmd;
	abas_pkg::cmd_t        head;
	abas_pkg::queue_stat_t stat;

	// take a word whenever the queue has room; an item that yields no
	// result still goes through the front to update the state
	assign item_ready = !stat.full;
	assign accept     = item_valid && item_ready;

	abas_front #(
		.MAX_ATTEMPTS(MAX_ATTEMPTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.reg_index(reg_index),
		.wr_data  (wr_data),
		.accept   (accept),
		.mode     (mode),
		.resp_byte(resp_byte),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decouple classification from result sequencing
	abas_queue #(
		.DEPTH(abas_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.stat    (stat)
	);

	// expand commands into result words; drop a command once its last word
	// is loaded into the output register
	abas_back #(
		.CANCEL_BURST(CANCEL_BURST)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.action    (action),
		.block_size(block_size),
		.aborted   (aborted),
		.last      (last)
	);

endmodule

// ===== rtl/abas_checker.sv =====
// ----------------------------------------------------------------------------
// abas_checker: port-level checks of the ARQ sender
// Watches the result channel for framing of single words and cancel bursts.
// ----------------------------------------------------------------------------
module abas_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [abas_pkg::ACTION_W-1:0]  action,
	input logic [abas_pkg::SIZE_W-1:0]    block_size,
	input logic                           aborted,
	input logic                           last
);

	// output is empty while reset is held
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// a stalled word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(action) &&
		$stable(block_size) && $stable(aborted) && $stable(last))
		else $error("stalled result changed");

	// abort flag only closes a cancel burst
	a_abort_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && aborted |-> last && action == abas_pkg::ACT_CANCEL)
		else $error("abort flag outside the end of a cancel burst");

	// every non-cancel word is a whole item
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && action != abas_pkg::ACT_CANCEL |-> last && !aborted)
		else $error("single result not marked last");

	// a burst word that is not last is followed at once by another cancel
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && action == abas_pkg::ACT_CANCEL && !last
		|=> res_valid && action == abas_pkg::ACT_CANCEL)
		else $error("cancel burst broken");

endmodule

bind adaptive_block_arq_sender_unit abas_checker u_abas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.action    (action),
	.block_size(block_size),
	.aborted   (aborted),
	.last      (last)
);
